### design/base64_codec_core_assert.svh
// Assertion macros for the base64 codec core.
// Used by base64_codec_core.sv; needs nothing else.
`ifndef BASE64_CODEC_CORE_ASSERT_SVH
`define BASE64_CODEC_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define B64C_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define B64C_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/b64c_pkg.sv
// Types, constants and alphabet functions for the base64 codec core.
// No dependencies; imported by base64_codec_core.
`default_nettype none

package b64c_pkg;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] data_in;
      logic       last_in;
   } b64c_req_type;

   typedef struct packed {
      logic [7:0] data_out;
      logic       last_out;
      logic       error;
   } b64c_rsp_type;

   // sextet -> character, standard alphabet
   function automatic logic [7:0] b64c_enc_char(input logic [5:0] v);
      logic [7:0] c;
      case (v) inside
         [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         c = CHAR_PLUS;
         default:       c = CHAR_SLASH;
      endcase
      return c;
   endfunction

   // character -> sextet; anything outside the alphabet (incl. pad) gives zero
   function automatic logic [5:0] b64c_dec_char(input logic [7:0] c);
      logic [7:0] d;
      case (c) inside
         [8'h41:8'h5A]: d = c - 8'h41;
         [8'h61:8'h7A]: d = c - 8'h61 + 8'd26;
         [8'h30:8'h39]: d = c - 8'h30 + 8'd52;
         CHAR_PLUS:     d = 8'd62;
         CHAR_SLASH:    d = 8'd63;
         default:       d = 8'd0;
      endcase
      return d[5:0];
   endfunction

endpackage

`default_nettype wire

### design/base64_codec_core.sv
// Streaming base64 codec, standard alphabet with '=' padding.
// Depends on b64c_pkg and base64_codec_core_assert.svh.
//
// Encode (mode 0) takes one byte per word and gives four characters for
// every third byte, or a padded group on the byte marked last. Decode
// (mode 1) takes one character per word and gives three bytes for every
// fourth, dropping one byte per '=' in the third and fourth position of the
// last group; a message ending inside a group gives one word with error
// set. Each input word is handled in the cycle it is accepted and its
// results are loaded into a four-word result buffer that drains one word
// per cycle on rsp while rsp_ready is high. A word that completes no
// group is taken every cycle; a word that completes a group is taken once
// the buffer is empty or is handing out its final word, so throughput is
// set by the result port. Mode writes clear any partial group and must be
// made idle.
`default_nettype none
`include "base64_codec_core_assert.svh"

module base64_codec_core
   import b64c_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire b64c_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output b64c_rsp_type      rsp_data,
   input  wire logic         csr_we,
   input  wire logic         csr_wdata
);

   logic         mode_ff;
   logic [17:0]  group_bits_ff, group_bits_in;
   logic [1:0]   group_count_ff, group_count_in;
   logic [1:0]   pad_seen_ff, pad_seen_in;
   b64c_rsp_type buf_ff [4];
   b64c_rsp_type buf_in [4];
   logic [2:0]   buf_cnt_ff;
   logic [1:0]   rd_idx_ff;

   logic [2:0]   held;
   logic         is_pad;
   logic [5:0]   sextet;
   logic [23:0]  triple;
   logic [2:0]   n_res;
   logic [2:0]   n_chars;
   logic [1:0]   drops;
   logic [1:0]   pad_upd;
   logic         produces;
   logic         req_take;
   logic         rsp_take;

   assign held     = {1'b0, group_count_ff} + 3'd1;
   assign is_pad   = (req_data.data_in == CHAR_PAD);
   assign sextet   = b64c_dec_char(req_data.data_in);
   assign produces = (mode_ff == MODE_DECODE) ? (held == 3'd4 || req_data.last_in)
                                              : (held == 3'd3 || req_data.last_in);

   assign req_ready = !produces || buf_cnt_ff == 3'd0 || (buf_cnt_ff == 3'd1 && rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = (buf_cnt_ff != 3'd0);
   assign rsp_take  = rsp_valid && rsp_ready;
   assign rsp_data  = buf_ff[rd_idx_ff];

   always_comb begin
      group_bits_in  = group_bits_ff;
      group_count_in = group_count_ff;
      pad_seen_in    = pad_seen_ff;
      n_res          = 3'd0;
      triple         = 24'd0;
      n_chars        = 3'd0;
      drops          = 2'd0;
      pad_upd        = pad_seen_ff;
      for (int k = 0; k < 4; k++) begin
         buf_in[k] = '0;
      end

      if (mode_ff == MODE_ENCODE) begin
         if (!produces) begin
            group_bits_in  = {group_bits_ff[9:0], req_data.data_in};
            group_count_in = held[1:0];
         end else begin
            // left-align the held bytes in the 24-bit group
            case (held)
               3'd1:    triple = {req_data.data_in, 16'd0};
               3'd2:    triple = {group_bits_ff[7:0], req_data.data_in, 8'd0};
               default: triple = {group_bits_ff[15:0], req_data.data_in};
            endcase
            n_chars = held + 3'd1;
            for (int k = 0; k < 4; k++) begin
               buf_in[k].data_out = (3'(k) < n_chars) ?
                                    b64c_enc_char(triple[(23 - 6 * k) -: 6]) : CHAR_PAD;
               buf_in[k].last_out = (k == 3) ? req_data.last_in : 1'b0;
               buf_in[k].error    = 1'b0;
            end
            n_res          = 3'd4;
            group_bits_in  = '0;
            group_count_in = 2'd0;
            pad_seen_in    = 2'd0;
         end
      end else begin
         pad_upd = pad_seen_ff | {(held == 3'd3) && is_pad, (held == 3'd4) && is_pad};
         if (held != 3'd4) begin
            if (req_data.last_in) begin
               // message ends inside a group
               buf_in[0].data_out = 8'd0;
               buf_in[0].last_out = 1'b1;
               buf_in[0].error    = 1'b1;
               n_res          = 3'd1;
               group_bits_in  = '0;
               group_count_in = 2'd0;
               pad_seen_in    = 2'd0;
            end else begin
               group_bits_in  = {group_bits_ff[11:0], sextet};
               group_count_in = held[1:0];
               pad_seen_in    = pad_upd;
            end
         end else begin
            triple = {group_bits_ff, sextet};
            if (req_data.last_in) begin
               drops = {1'b0, pad_upd[1]} + {1'b0, pad_upd[0]};
            end
            n_res = 3'd3 - {1'b0, drops};
            for (int k = 0; k < 3; k++) begin
               buf_in[k].data_out = triple[(23 - 8 * k) -: 8];
               buf_in[k].last_out = (3'(k + 1) == n_res) ? req_data.last_in : 1'b0;
               buf_in[k].error    = 1'b0;
            end
            group_bits_in  = '0;
            group_count_in = 2'd0;
            pad_seen_in    = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_ENCODE;
         group_bits_ff  <= '0;
         group_count_ff <= 2'd0;
         pad_seen_ff    <= 2'd0;
      end else if (csr_we) begin
         mode_ff        <= csr_wdata;
         group_bits_ff  <= '0;
         group_count_ff <= 2'd0;
         pad_seen_ff    <= 2'd0;
      end else if (req_take) begin
         group_bits_ff  <= group_bits_in;
         group_count_ff <= group_count_in;
         pad_seen_ff    <= pad_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_cnt_ff <= 3'd0;
         rd_idx_ff  <= 2'd0;
      end else if (req_take && n_res != 3'd0) begin
         buf_cnt_ff <= n_res;
         rd_idx_ff  <= 2'd0;
      end else if (rsp_take) begin
         buf_cnt_ff <= buf_cnt_ff - 3'd1;
         rd_idx_ff  <= rd_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && n_res != 3'd0) begin
         for (int k = 0; k < 4; k++) begin
            buf_ff[k] <= buf_in[k];
         end
      end
   end

   `B64C_ASSERT_IMP(a_buf_cnt_range, clock, reset, 1'b1, buf_cnt_ff <= 3'd4,
                    "result buffer count above four")
   `B64C_ASSERT_IMP(a_error_is_last, clock, reset, rsp_valid && rsp_data.error,
                    rsp_data.last_out && rsp_data.data_out == 8'd0,
                    "error word not marked last")
   `B64C_ASSERT_IMP(a_encode_no_error, clock, reset, rsp_valid && mode_ff == MODE_ENCODE,
                    !rsp_data.error, "error flagged while encoding")
   `B64C_ASSERT_NXT(a_drain_empties, clock, reset,
                    rsp_take && buf_cnt_ff == 3'd1 && !(req_take && n_res != 3'd0),
                    !rsp_valid, "result buffer not empty after final word")

endmodule

`default_nettype wire

### test/base64_codec_checker.sv
`timescale 1ns / 100ps
// Scoreboard for base64_codec_core: predicts the result words from the
// accepted request words and mode writes, and compares each response word.
// Depends on b64c_pkg for the word types and the mode and pad constants.

module base64_codec_checker
   import b64c_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  b64c_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  b64c_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_wdata,
   output int           due_count,
   output int           fail_count
);

   b64c_rsp_type codec_words_due[$];

   logic        cur_mode;
   logic [17:0] held_bits;
   logic [1:0]  held_count;
   logic [1:0]  pad_flags;
   int          fails;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) return 8'h41 + 8'(v);
      if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
      if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
      if (v == 6'd62) return CHAR_PLUS;
      return CHAR_SLASH;
   endfunction

   // anything outside the alphabet counts as zero, pad included
   function automatic logic [5:0] char_sextet(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
      if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26);
      if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
      if (c == CHAR_PLUS) return 6'd62;
      if (c == CHAR_SLASH) return 6'd63;
      return 6'd0;
   endfunction

   task automatic clear_group;
      held_bits  = '0;
      held_count = '0;
      pad_flags  = '0;
   endtask

   task automatic queue_word(input logic [7:0] d, input logic l, input logic e);
      b64c_rsp_type w;
      w.data_out = d;
      w.last_out = l;
      w.error    = e;
      codec_words_due.push_back(w);
   endtask

   task automatic predict_codec(input b64c_req_type w);
      logic [2:0]  held;
      logic [23:0] triple;
      logic [5:0]  s;
      int          nbytes;
      held = {1'b0, held_count} + 3'd1;
      if (cur_mode == MODE_ENCODE) begin
         if (held < 3'd3 && !w.last_in) begin
            held_bits  = {held_bits[9:0], w.data_in};
            held_count = held[1:0];
         end else begin
            case (held)
               3'd1:    triple = {w.data_in, 16'h0000};
               3'd2:    triple = {held_bits[7:0], w.data_in, 8'h00};
               default: triple = {held_bits[15:0], w.data_in};
            endcase
            for (int k = 0; k < 4; k++) begin
               queue_word((k <= int'(held)) ? sextet_char(triple[18 - 6 * k +: 6]) : CHAR_PAD,
                          (k == 3) ? w.last_in : 1'b0, 1'b0);
            end
            clear_group;
         end
      end else begin
         s = (w.data_in == CHAR_PAD) ? 6'd0 : char_sextet(w.data_in);
         if (held == 3'd3 && w.data_in == CHAR_PAD) pad_flags[1] = 1'b1;
         if (held == 3'd4 && w.data_in == CHAR_PAD) pad_flags[0] = 1'b1;
         if (held < 3'd4) begin
            if (w.last_in) begin
               // message ends inside a group
               queue_word(8'h00, 1'b1, 1'b1);
               clear_group;
            end else begin
               held_bits  = {held_bits[11:0], s};
               held_count = held[1:0];
            end
         end else begin
            triple = {held_bits, s};
            nbytes = 3;
            if (w.last_in) nbytes = 3 - int'(pad_flags[1]) - int'(pad_flags[0]);
            for (int k = 0; k < nbytes; k++) begin
               queue_word(triple[16 - 8 * k +: 8], (k == nbytes - 1) ? w.last_in : 1'b0, 1'b0);
            end
            clear_group;
         end
      end
   endtask

   always @(posedge clock) begin
      b64c_rsp_type want;
      if (reset) begin
         codec_words_due.delete();
         cur_mode = MODE_ENCODE;
         clear_group;
         fails = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (codec_words_due.size() == 0) begin
               $display("%0t: unexpected word data=%h last=%b error=%b", $time,
                        rsp_data.data_out, rsp_data.last_out, rsp_data.error);
               fails++;
            end else begin
               want = codec_words_due.pop_front();
               if (rsp_data.data_out !== want.data_out) begin
                  $display("%0t: data_out expected %h got %h", $time,
                           want.data_out, rsp_data.data_out);
                  fails++;
               end
               if (rsp_data.last_out !== want.last_out) begin
                  $display("%0t: last_out expected %b got %b", $time,
                           want.last_out, rsp_data.last_out);
                  fails++;
               end
               if (rsp_data.error !== want.error) begin
                  $display("%0t: error expected %b got %b", $time,
                           want.error, rsp_data.error);
                  fails++;
               end
            end
         end
         // a mode write drops any partial group
         if (csr_we) begin
            cur_mode = csr_wdata;
            clear_group;
         end
         if (req_valid && req_ready) predict_codec(req_data);
      end
      due_count  <= codec_words_due.size();
      fail_count <= fails;
   end

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// Top of the base64_codec_core bench: clock, reset, request and mode
// stimulus, response back-pressure, stall watchdog and verdict.
// Depends on b64c_pkg, base64_codec_core and base64_codec_checker.

module tb;
   import b64c_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int TAIL_CYCLES = 8;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   b64c_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   b64c_rsp_type rsp_data;
   logic         csr_we    = 1'b0;
   logic         csr_wdata = 1'b0;

   int   due_count;
   int   fail_count;
   int   words_sent = 0;
   int   stall_cycles = 0;
   logic steady = 1'b0;

   always #6 clock = ~clock;

   base64_codec_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   base64_codec_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .due_count  (due_count),
      .fail_count (fail_count)
   );

   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_word(input logic [7:0] d, input logic l);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 15) gap = $urandom_range(1, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {d, l};
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic push_text(input string s, input logic l);
      for (int i = 0; i < s.len(); i++) push_word(s[i], l && (i == s.len() - 1));
   endtask

   // hold off until every due word is out, then add the TAIL_CYCLES slack
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(negedge clock); while (due_count != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain_results;
      csr_wdata <= m;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [7:0] alpha_char(input int v);
      if (v < 26) return 8'(8'h41 + v);
      if (v < 52) return 8'(8'h61 + v - 26);
      if (v < 62) return 8'(8'h30 + v - 52);
      return (v == 62) ? CHAR_PLUS : CHAR_SLASH;
   endfunction

   task automatic encode_message;
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 7);
      for (int i = 0; i < len; i++) push_word(8'($urandom_range(255)), i == len - 1);
   endtask

   task automatic decode_message;
      int          groups, shape, len;
      logic [7:0]  c;
      if ($urandom_range(99) < 80) begin
         groups = $urandom_range(0, 3);
         for (int i = 0; i < 4 * groups; i++) begin
            // now and then a pad in mid message
            c = ($urandom_range(29) == 0) ? CHAR_PAD : alpha_char($urandom_range(63));
            push_word(c, 1'b0);
         end
         shape = $urandom_range(2);
         for (int i = 0; i < 4; i++) begin
            c = alpha_char($urandom_range(63));
            if (shape == 1 && i >= 2) c = CHAR_PAD;
            if (shape == 2 && i == 3) c = CHAR_PAD;
            push_word(c, i == 3);
         end
      end else begin
         len = $urandom_range(1, 9);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(2))
               0:       c = 8'($urandom_range(255));
               1:       c = CHAR_PAD;
               default: c = alpha_char($urandom_range(63));
            endcase
            push_word(c, i == len - 1);
         end
      end
   endtask

   initial begin
      logic phase_modes [8];
      int   target;
      phase_modes = '{MODE_ENCODE, MODE_DECODE, MODE_DECODE, MODE_ENCODE,
                      MODE_ENCODE, MODE_DECODE, MODE_ENCODE, MODE_DECODE};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // encode: full group, one and two byte tails, extremes of the byte
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h7F, 1'b0);
      push_word(8'hFB, 1'b1);
      push_word(8'h03, 1'b0);
      push_word(8'hEF, 1'b1);
      // partial group, thrown away by the mode write
      push_word(8'h55, 1'b0);
      write_mode(MODE_DECODE);
      push_text("+/z=", 1'b0);  // pad in mid message keeps all three bytes
      push_text("TQ==", 1'b1);
      push_text("*=E=", 1'b1);  // out of alphabet, pad in second position
      push_text("TQ=", 1'b1);   // ends inside a group
      push_text("Z", 1'b1);

      for (int p = 0; p < 8; p++) begin
         write_mode(phase_modes[p]);
         steady <= (p == 2);
         target = 23 + (p + 1) * 49;
         while (words_sent < target) begin
            if (phase_modes[p] == MODE_ENCODE) encode_message;
            else decode_message;
            if (p == 4 || $urandom_range(15) == 0) drain_results;
         end
      end
      drain_results;

      if (fail_count == 0 && due_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+design
design/b64c_pkg.sv
design/base64_codec_core.sv
test/base64_codec_checker.sv
test/tb.sv
